/* sv/mtf_pkg.sv */
// Package: types, sizes and codes for the move-to-front recent list.
package mtf_pkg;

    localparam int DEPTH    = 16;
    localparam int KEY_BITS = 64;

    localparam int KEY_W   = 64;
    localparam int INDEX_W = 4;
    localparam int COUNT_W = 5;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_READ   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADD,
        ST_REM,
        ST_RD
    } state_t;

    typedef struct packed {
        op_t                opcode;
        logic [KEY_W-1:0]   key;
        logic [INDEX_W-1:0] index;
    } req_t;

    typedef struct packed {
        logic [KEY_W-1:0]   result_key;
        logic               hit;
        logic               changed;
        logic [COUNT_W-1:0] entry_count;
    } rsp_t;

endpackage

/* sv/move_to_front_recent_list_core.sv */
// Top level: most-recent-first key list held in one synchronous memory.
//
//  channel | direction | handshake                       | payload
//  --------+-----------+---------------------------------+--------
//  request | in        | start, taken when busy is low   | req (req_t)
//  result  | out       | done, high for one cycle        | rsp (rsp_t)
//
// Clear, an add of an empty key or to an empty list, and an out-of-range remove or
// read return a result straight from idle; a read in range passes through the read
// state. An add walks one entry per cycle to the duplicate or the end; a remove
// walks from the index to the end.
// Reset clears the state, the count and done only; words at or above the count never reach a result.
// The receiver cannot stall; busy holds off new requests during a walk.
module move_to_front_recent_list_core
    import mtf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t req,
    output logic done,
    output rsp_t rsp
);

    // Entry storage: one write and one registered read per cycle.
    logic [KEY_BITS-1:0] mem [DEPTH];
    logic [KEY_BITS-1:0] rd_data;
    logic                mem_we;
    logic [IDX_W-1:0]    waddr;
    logic [IDX_W-1:0]    raddr;
    logic [KEY_BITS-1:0] wdata;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [IDX_W-1:0]    ptr_reg, ptr_next;
    logic [KEY_BITS-1:0] carry_reg, carry_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    rsp_t                rsp_reg, rsp_next;
    logic                done_reg, done_next;

    logic                accept;
    logic [KEY_BITS-1:0] req_key;
    logic                idx_in;
    logic [CNT_W-1:0]    ptr_ext;
    logic                ptr_at_end;
    logic                ptr_last;
    logic                full;
    logic                match;
    rsp_t                rsp_idle;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[waddr] <= wdata;
        end
        rd_data <= mem[raddr];
    end

    assign accept     = start && (state_reg == ST_IDLE);
    assign req_key    = req.key[KEY_BITS-1:0];
    assign idx_in     = CMP_W'(req.index) < CMP_W'(count_reg);
    assign ptr_ext    = CNT_W'(ptr_reg);
    assign ptr_at_end = (ptr_ext == count_reg);
    assign ptr_last   = (CNT_W'(ptr_ext + CNT_W'(1)) == count_reg);
    assign full       = (count_reg == CNT_W'(DEPTH));
    assign match      = (rd_data == key_reg);

    // Result that leaves the list as it is.
    always_comb
    begin
        rsp_idle             = '0;
        rsp_idle.entry_count = COUNT_W'(count_reg);
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (req.opcode)
                        OP_ADD:
                        begin
                            if ((req_key != '0) && (count_reg != '0))
                            begin
                                state_next = ST_ADD;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (idx_in)
                            begin
                                state_next = ST_REM;
                            end
                        end
                        OP_READ:
                        begin
                            if (idx_in)
                            begin
                                state_next = ST_RD;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_ADD:
            begin
                if (ptr_at_end || match || (ptr_last && full))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_REM:
            begin
                if (ptr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RD:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Memory control, walk registers and result.
    always_comb
    begin
        mem_we     = 1'b0;
        waddr      = ptr_reg;
        wdata      = carry_reg;
        raddr      = IDX_W'(ptr_ext + CNT_W'(1));
        count_next = count_reg;
        ptr_next   = ptr_reg;
        carry_next = carry_reg;
        key_next   = key_reg;
        rsp_next   = rsp_reg;
        done_next  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    key_next   = req_key;
                    carry_next = req_key;
                    ptr_next   = '0;
                    case (req.opcode)
                        OP_ADD:
                        begin
                            raddr = '0;
                            if (req_key == '0)
                            begin
                                // Empty word: drop the request.
                                done_next = 1'b1;
                                rsp_next  = rsp_idle;
                            end
                            else if (count_reg == '0)
                            begin
                                // Empty list: store at the front directly.
                                mem_we               = 1'b1;
                                waddr                = '0;
                                wdata                = req_key;
                                count_next           = CNT_W'(1);
                                done_next            = 1'b1;
                                rsp_next             = '0;
                                rsp_next.changed     = 1'b1;
                                rsp_next.entry_count = COUNT_W'(1);
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (idx_in)
                            begin
                                ptr_next = IDX_W'(req.index);
                                raddr    = IDX_W'(CMP_W'(req.index) + CMP_W'(1));
                            end
                            else
                            begin
                                done_next = 1'b1;
                                rsp_next  = rsp_idle;
                            end
                        end
                        OP_CLEAR:
                        begin
                            count_next       = '0;
                            done_next        = 1'b1;
                            rsp_next         = '0;
                            rsp_next.changed = (count_reg != '0);
                        end
                        OP_READ:
                        begin
                            if (idx_in)
                            begin
                                raddr = IDX_W'(req.index);
                            end
                            else
                            begin
                                done_next = 1'b1;
                                rsp_next  = rsp_idle;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b0;
                        end
                    endcase
                end
            end
            ST_ADD:
            begin
                // Write the carried key into this slot, carry the old one on.
                mem_we = 1'b1;
                if (ptr_at_end)
                begin
                    count_next           = CNT_W'(count_reg + CNT_W'(1));
                    done_next            = 1'b1;
                    rsp_next             = '0;
                    rsp_next.changed     = 1'b1;
                    rsp_next.entry_count = COUNT_W'(count_reg + CNT_W'(1));
                end
                else if (match)
                begin
                    done_next        = 1'b1;
                    rsp_next         = rsp_idle;
                    rsp_next.hit     = 1'b1;
                    rsp_next.changed = 1'b1;
                end
                else if (ptr_last && full)
                begin
                    // Oldest entry falls off the end.
                    done_next        = 1'b1;
                    rsp_next         = rsp_idle;
                    rsp_next.changed = 1'b1;
                end
                else
                begin
                    carry_next = rd_data;
                    ptr_next   = IDX_W'(ptr_ext + CNT_W'(1));
                    raddr      = IDX_W'(ptr_ext + CNT_W'(1));
                end
            end
            ST_REM:
            begin
                if (!ptr_last)
                begin
                    // Pull the next entry up into this slot.
                    mem_we   = 1'b1;
                    wdata    = rd_data;
                    ptr_next = IDX_W'(ptr_ext + CNT_W'(1));
                    raddr    = IDX_W'(ptr_ext + CNT_W'(2));
                end
                else
                begin
                    count_next           = CNT_W'(count_reg - CNT_W'(1));
                    done_next            = 1'b1;
                    rsp_next             = '0;
                    rsp_next.hit         = 1'b1;
                    rsp_next.changed     = 1'b1;
                    rsp_next.entry_count = COUNT_W'(count_reg - CNT_W'(1));
                end
            end
            ST_RD:
            begin
                done_next           = 1'b1;
                rsp_next            = rsp_idle;
                rsp_next.result_key = KEY_W'(rd_data);
                rsp_next.hit        = 1'b1;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg   <= ptr_next;
        carry_reg <= carry_next;
        key_reg   <= key_next;
        rsp_reg   <= rsp_next;
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above list depth");

    a_add_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ADD) |-> (ptr_ext <= count_reg))
        else $error("add walk ran past the end of the list");

    a_clear_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req.opcode == OP_CLEAR)) |=> (done && (rsp.entry_count == '0)))
        else $error("clear did not report an empty list");

    a_read_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD) |=> (done && rsp.hit && !rsp.changed))
        else $error("read in range did not report a hit");

    a_walk_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (busy && !$past(done_next)) |-> !done)
        else $error("result strobe while a walk is in progress");
`endif

endmodule
